FILE: rtl/lmtsi_pkg.sv
// lmtsi_pkg: types and constants for the display mode timing sequencer
// no dependencies; used by lcd_mode_timing_stat_irq_core
`default_nettype none

package lmtsi_pkg;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } mode_t;

    // line timing in machine cycles
    localparam logic [15:0] OAM_LEN      = 16'd20;
    localparam logic [15:0] TRANSFER_LEN = 16'd43;
    localparam logic [15:0] HBLANK_LEN   = 16'd51;
    localparam logic [15:0] LINE_TOTAL   = 16'd114;
    localparam logic [15:0] OAM_END      = OAM_LEN;
    localparam logic [15:0] TRANSFER_END = OAM_LEN + TRANSFER_LEN;
    localparam logic [15:0] HBLANK_END   = OAM_LEN + TRANSFER_LEN + HBLANK_LEN;
    localparam logic [15:0] COUNT_MAX    = 16'hffff;

    localparam logic [7:0] LAST_LINE   = 8'd153;
    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] RESET_LINE  = 8'd145;

    // bit positions within the status byte
    localparam int STAT_HBLANK_BIT  = 3;
    localparam int STAT_VBLANK_BIT  = 4;
    localparam int STAT_OAM_BIT     = 5;
    localparam int STAT_COMPARE_BIT = 6;
    localparam logic [7:0] COMPARE_ENABLE = 8'(1 << STAT_COMPARE_BIT);

    // bus register offsets from the register base
    localparam logic [15:0] REG_BASE     = 16'hff40;
    localparam logic [3:0]  OFS_STATUS   = 4'(16'hff41 - REG_BASE);
    localparam logic [3:0]  OFS_LINE     = 4'(16'hff44 - REG_BASE);
    localparam logic [3:0]  OFS_COMPARE  = 4'(16'hff45 - REG_BASE);

endpackage

`default_nettype wire

FILE: rtl/lcd_mode_timing_stat_irq_core.sv
// lcd_mode_timing_stat_irq_core: scanline mode timing sequencer with status requests
// depends on lmtsi_pkg
//
// usage:
// - input channel (in_valid / in_stall) carries one item per transaction: a tick
//   with an absolute cycle_count, or a bus read or write of the status (offset 1),
//   current line (offset 4) or compare line (offset 5) register
// - output channel (out_valid / out_stall) returns exactly one result per item:
//   read data, mode and scanline after the item, vblank and status request
//   pulses, and a flag for an unimplemented register offset
// - each item passes through the input register, then the mode/line update into
//   the result register; out_valid rises once the result register is loaded
// - throughput is one item per cycle while the receiver does not stall; the single
//   add-and-compare of the cycle count against the mode thresholds sets that figure
// - when the receiver stalls, the result register holds and the input register
//   still takes one more item; in_stall rises once both are full
// - reset leaves the block in vblank at line 145 with the cycle counter, the
//   last cycle count, the status enables and the compare line cleared
`default_nettype none

module lcd_mode_timing_stat_irq_core #(
    parameter int CYCLE_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [3:0]  reg_index,
    input  wire logic [7:0]  write_data,
    input  wire logic [31:0] cycle_count,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       read_data,
    output logic [1:0]       mode,
    output logic [7:0]       scanline,
    output logic             vblank_request,
    output logic             status_request,
    output logic             bad_register
);

    // input register
    logic                     a_valid_reg;
    lmtsi_pkg::action_t       a_action_reg;
    logic [3:0]               a_index_reg;
    logic [7:0]               a_data_reg;
    logic [CYCLE_WIDTH-1:0]   a_now_reg;

    // sequencer state
    lmtsi_pkg::mode_t         mode_reg, mode_next;
    logic [7:0]               line_reg, line_next;
    logic [15:0]              count_reg, count_next;
    logic [CYCLE_WIDTH-1:0]   last_cycle_reg, last_cycle_next;
    logic [5:0]               enables_reg, enables_next;
    logic [7:0]               compare_reg, compare_next;

    // result register
    logic                     out_valid_reg;
    logic [7:0]               read_data_reg, read_data_next;
    logic                     vblank_req_reg, vblank_req_next;
    logic                     status_req_reg, status_req_next;
    logic                     bad_reg, bad_next;
    lmtsi_pkg::mode_t         out_mode_reg;
    logic [7:0]               out_line_reg;

    logic                     out_free;
    logic                     advance;
    logic                     in_accept;
    logic [CYCLE_WIDTH+31:0]  now_ext;

    // tick datapath
    logic [CYCLE_WIDTH-1:0]   elapsed;
    logic [15:0]              headroom;
    logic [15:0]              count_sum;
    logic [7:0]               stat;
    logic [7:0]               line_inc;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = a_valid_reg && out_free;
    assign in_stall  = a_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign now_ext   = {{CYCLE_WIDTH{1'b0}}, cycle_count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_action_reg <= lmtsi_pkg::action_t'(action);
            a_index_reg  <= reg_index;
            a_data_reg   <= write_data;
            a_now_reg    <= now_ext[CYCLE_WIDTH-1:0];
        end
    end

    assign elapsed   = a_now_reg - last_cycle_reg;
    assign headroom  = lmtsi_pkg::COUNT_MAX - count_reg;
    assign count_sum = count_reg + elapsed[15:0];
    assign stat      = {enables_reg, 2'b00};
    assign line_inc  = line_reg + 8'd1;

    always_comb
    begin
        logic [15:0] cnt;
        mode_next       = mode_reg;
        line_next       = line_reg;
        count_next      = count_reg;
        last_cycle_next = last_cycle_reg;
        enables_next    = enables_reg;
        compare_next    = compare_reg;
        read_data_next  = 8'd0;
        vblank_req_next = 1'b0;
        status_req_next = 1'b0;
        bad_next        = 1'b0;
        cnt             = count_reg;

        case (a_action_reg)
            lmtsi_pkg::ACT_TICK:
            begin
                if (elapsed >= CYCLE_WIDTH'(headroom))
                begin
                    cnt = lmtsi_pkg::COUNT_MAX;
                end
                else
                begin
                    cnt = count_sum;
                end
                count_next      = cnt;
                last_cycle_next = a_now_reg;

                unique case (mode_reg)
                    lmtsi_pkg::MODE_OAM:
                    begin
                        if (cnt >= lmtsi_pkg::OAM_END)
                        begin
                            mode_next = lmtsi_pkg::MODE_TRANSFER;
                        end
                    end
                    lmtsi_pkg::MODE_TRANSFER:
                    begin
                        if (cnt >= lmtsi_pkg::TRANSFER_END)
                        begin
                            mode_next = lmtsi_pkg::MODE_HBLANK;
                        end
                    end
                    lmtsi_pkg::MODE_HBLANK:
                    begin
                        if (cnt >= lmtsi_pkg::HBLANK_END)
                        begin
                            line_next  = line_inc;
                            count_next = 16'd0;
                            if (line_inc == lmtsi_pkg::VBLANK_LINE)
                            begin
                                mode_next       = lmtsi_pkg::MODE_VBLANK;
                                vblank_req_next = 1'b1;
                            end
                            else
                            begin
                                mode_next = lmtsi_pkg::MODE_OAM;
                            end
                        end
                    end
                    default:
                    begin
                        if (cnt >= lmtsi_pkg::LINE_TOTAL)
                        begin
                            count_next = 16'd0;
                            if (line_reg == lmtsi_pkg::LAST_LINE)
                            begin
                                mode_next = lmtsi_pkg::MODE_OAM;
                                line_next = 8'd0;
                            end
                            else
                            begin
                                line_next = line_inc;
                            end
                        end
                    end
                endcase

                // line compare on a line change
                if ((line_next != line_reg) && ((stat & lmtsi_pkg::COMPARE_ENABLE) != 8'd0)
                    && (line_next == compare_reg))
                begin
                    status_req_next = 1'b1;
                end

                // enabled mode entry
                if (mode_next != mode_reg)
                begin
                    case (mode_next)
                        lmtsi_pkg::MODE_OAM:
                            if (stat[lmtsi_pkg::STAT_OAM_BIT]) status_req_next = 1'b1;
                        lmtsi_pkg::MODE_HBLANK:
                            if (stat[lmtsi_pkg::STAT_HBLANK_BIT]) status_req_next = 1'b1;
                        lmtsi_pkg::MODE_VBLANK:
                            if (stat[lmtsi_pkg::STAT_VBLANK_BIT]) status_req_next = 1'b1;
                        default:
                        begin
                        end
                    endcase
                end
            end
            lmtsi_pkg::ACT_READ:
            begin
                unique case (a_index_reg)
                    lmtsi_pkg::OFS_STATUS:  read_data_next = {enables_reg, mode_reg};
                    lmtsi_pkg::OFS_LINE:    read_data_next = line_reg;
                    lmtsi_pkg::OFS_COMPARE: read_data_next = compare_reg;
                    default:                bad_next = 1'b1;
                endcase
            end
            lmtsi_pkg::ACT_WRITE:
            begin
                unique case (a_index_reg)
                    lmtsi_pkg::OFS_STATUS:  enables_next = a_data_reg[7:2];
                    lmtsi_pkg::OFS_LINE:
                    begin
                        line_next = 8'd0;
                        mode_next = lmtsi_pkg::MODE_OAM;
                    end
                    lmtsi_pkg::OFS_COMPARE: compare_next = a_data_reg;
                    default:                bad_next = 1'b1;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lmtsi_pkg::MODE_VBLANK;
            line_reg       <= lmtsi_pkg::RESET_LINE;
            count_reg      <= 16'd0;
            last_cycle_reg <= '0;
            enables_reg    <= 6'd0;
            compare_reg    <= 8'd0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            line_reg       <= line_next;
            count_reg      <= count_next;
            last_cycle_reg <= last_cycle_next;
            enables_reg    <= enables_next;
            compare_reg    <= compare_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg  <= read_data_next;
            vblank_req_reg <= vblank_req_next;
            status_req_reg <= status_req_next;
            bad_reg        <= bad_next;
            out_mode_reg   <= mode_next;
            out_line_reg   <= line_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = read_data_reg;
    assign mode           = out_mode_reg;
    assign scanline       = out_line_reg;
    assign vblank_request = vblank_req_reg;
    assign status_request = status_req_reg;
    assign bad_register   = bad_reg;

    // a vblank request only comes with vblank entered at the vblank line
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && vblank_req_reg) |->
            (out_mode_reg == lmtsi_pkg::MODE_VBLANK && out_line_reg == lmtsi_pkg::VBLANK_LINE))
        else $error("vblank request without vblank entry at the vblank line");

    // a bad offset reads as zero and raises no request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_reg) |->
            (read_data_reg == 8'd0 && !vblank_req_reg && !status_req_reg))
        else $error("bad register access carried data or a request");

    // bus transactions never move the cycle reference
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && a_action_reg != lmtsi_pkg::ACT_TICK) |=> $stable(last_cycle_reg))
        else $error("bus transaction changed the last cycle count");

    // the result shows the state left behind by its item
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_mode_reg == mode_reg && out_line_reg == line_reg))
        else $error("result mode or line differs from sequencer state");

endmodule

`default_nettype wire
